>>> src/rgbycc_pkg.sv
// Shared constants, tables, types and helpers for the RGB to YCbCr subsampling core.
package rgbycc_pkg;

	// Fixed field and register widths.
	localparam int PIX_W     = 8;
	localparam int IN_W      = 3 * PIX_W;
	localparam int OUT_W     = 3 * PIX_W;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;
	localparam int FACT_W    = 3;
	localparam int CNT_W     = 12;
	localparam int ACC_W     = 16;
	localparam int SUM_W     = 26;

	// Default sizing of the accumulator store and the block side, and the row limit.
	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_FACTOR = 4;
	localparam int HEIGHT_LIMIT   = 4096;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FACTOR = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [CFG_W-1:0]  RST_WIDTH  = 13'd640;
	localparam logic [CFG_W-1:0]  RST_HEIGHT = 13'd480;
	localparam logic [FACT_W-1:0] RST_FACTOR = 3'd2;

	// BT.601 studio-range coefficients in Q16.
	localparam int Y_OFF  = 16 << 16;
	localparam int Y_R    = 16829;
	localparam int Y_G    = 33039;
	localparam int Y_B    = 6416;
	localparam int CB_OFF = 128 << 16;
	localparam int CB_R   = -9714;
	localparam int CB_G   = -19070;
	localparam int CB_B   = 28784;
	localparam int CR_OFF = 128 << 16;
	localparam int CR_R   = 28784;
	localparam int CR_G   = -24103;
	localparam int CR_B   = -4681;

	// Column split: floor(c / f) = (c * COL_RECIP[f]) >> DIV_SHIFT for any 12-bit c.
	localparam int DIV_SHIFT = 15;
	localparam int COL_RC_W  = 16;
	localparam logic [COL_RC_W-1:0] COL_RECIP [8] = '{
		16'd32768, 16'd32768, 16'd16384, 16'd10923,
		16'd8192,  16'd6554,  16'd5462,  16'd4682
	};

	// Block average: floor(s / f^2) = (s * AVG_RECIP[f]) >> AVG_SHIFT for any 17-bit s.
	localparam int AVG_SHIFT = 23;
	localparam int AVG_RC_W  = 24;
	localparam logic [AVG_RC_W-1:0] AVG_RECIP [8] = '{
		24'd8388608, 24'd8388608, 24'd2097152, 24'd932068,
		24'd524288,  24'd335545,  24'd233017,  24'd171197
	};

	typedef struct packed {
		logic clear;
		logic capture;
		logic split;
		logic read;
		logic accum;
		logic average;
		logic load;
	} rgbycc_cmd_t;

	typedef struct packed {
		logic clear_done;
	} rgbycc_status_t;

	// Negative gives zero, otherwise drop the fraction and saturate to 255.
	function automatic logic [PIX_W-1:0] clamp_q16(input logic signed [SUM_W-1:0] v);
		logic [PIX_W-1:0] res;
		if (v < 0) begin
			res = '0;
		end else if (v[SUM_W-2:16] > 9'd255) begin
			res = '1;
		end else begin
			res = v[16 +: PIX_W];
		end
		return res;
	endfunction

endpackage

>>> src/rgb_to_ycbcr_chroma_subsample_core.sv
// Top level of the RGB to BT.601 YCbCr converter with box chroma subsampling.
//
//   Channel   Direction  Width  Contents
//   s_axis    in         24     tdata: red[7:0], green[15:8], blue[23:16]
//   m_axis    out        24+1+1 tdata: luma, blue_diff, red_diff; tuser: chroma_valid;
//                                tlast: frame_end
//   cfg       in         1+2+13 cfg_we, cfg_index (width, height, factor), cfg_data
//
// The controller takes each pixel word one state a cycle through split, read,
// accumulate (add and write-back together), average and load, and accepts no new
// word until the load is done; the result word is registered onto m_axis at the load.
// After reset the accumulator store is cleared one entry a cycle, all MAX_WIDTH entries,
// before s_axis_tready rises. A stalled output holds the block before its final step.
module rgb_to_ycbcr_chroma_subsample_core #(
	parameter int MAX_WIDTH  = rgbycc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_FACTOR = rgbycc_pkg::DEF_MAX_FACTOR
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [rgbycc_pkg::IN_W-1:0]      s_axis_tdata,  // red, green, blue
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [rgbycc_pkg::OUT_W-1:0]     m_axis_tdata,  // luma, blue_diff, red_diff
	output logic                             m_axis_tuser,  // chroma_valid
	output logic                             m_axis_tlast,
	input  logic                             cfg_we,
	input  logic [rgbycc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rgbycc_pkg::CFG_W-1:0]     cfg_data
);
	import rgbycc_pkg::*;

	rgbycc_cmd_t    cmd;
	rgbycc_status_t status;

	rgbycc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.cmd      (cmd),
		.status   (status)
	);

	rgbycc_dp #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_FACTOR(MAX_FACTOR)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_data  (s_axis_tdata),
		.out_data  (m_axis_tdata),
		.out_chroma(m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

endmodule

>>> src/rgbycc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module rgbycc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> src/rgbycc_ctrl.sv
// Controller state machine: stream handshakes and sequencing of the datapath steps.
module rgbycc_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	output logic                       out_valid,
	input  logic                       out_ready,
	output rgbycc_pkg::rgbycc_cmd_t    cmd,
	input  rgbycc_pkg::rgbycc_status_t status
);
	import rgbycc_pkg::*;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SPLIT = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_ACCUM = 3'd4;
	localparam logic [2:0] ST_AVG   = 3'd5;
	localparam logic [2:0] ST_LOAD  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	// The output register can take a new word when empty or being drained now.
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.clear   = (state_q == ST_CLEAR);
		cmd.capture = in_valid && (state_q == ST_IDLE);
		cmd.split   = (state_q == ST_SPLIT);
		cmd.read    = (state_q == ST_READ);
		cmd.accum   = (state_q == ST_ACCUM);
		cmd.average = (state_q == ST_AVG);
		cmd.load    = (state_q == ST_LOAD) && out_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (status.clear_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_SPLIT;
			end
			ST_SPLIT: state_d = ST_READ;
			ST_READ:  state_d = ST_ACCUM;
			ST_ACCUM: state_d = ST_AVG;
			ST_AVG:   state_d = ST_LOAD;
			ST_LOAD: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath step commanded at once");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> out_valid)
		else $error("loaded result word not presented");

	a_load_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !(out_valid_q && !out_ready))
		else $error("result word overwritten before it was taken");

endmodule

>>> src/rgbycc_dp.sv
// Datapath: configuration, counters, colour conversion, chroma accumulators and averaging.
module rgbycc_dp #(
	parameter int MAX_WIDTH  = rgbycc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_FACTOR = rgbycc_pkg::DEF_MAX_FACTOR
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rgbycc_pkg::rgbycc_cmd_t         cmd,
	output rgbycc_pkg::rgbycc_status_t      status,
	input  logic                            cfg_we,
	input  logic [rgbycc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rgbycc_pkg::CFG_W-1:0]    cfg_data,
	input  logic [rgbycc_pkg::IN_W-1:0]     pix_data,
	output logic [rgbycc_pkg::OUT_W-1:0]    out_data,
	output logic                            out_chroma,
	output logic                            out_last
);
	import rgbycc_pkg::*;

	localparam int AddrW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RibW   = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
	localparam int DivpW  = CNT_W + COL_RC_W;
	localparam int BaseW  = CNT_W + FACT_W;
	localparam int SumQW  = ACC_W + 1;
	localparam int AvgpW  = SumQW + AVG_RC_W;

	// Configuration and position counters.
	logic [CFG_W-1:0]  image_width_q;
	logic [CFG_W-1:0]  image_height_q;
	logic [FACT_W-1:0] subsample_factor_q;
	logic [CNT_W-1:0]  column_q;
	logic [CNT_W-1:0]  row_q;
	logic [RibW-1:0]   rib_q;
	logic [AddrW-1:0]  clear_addr_q;

	logic [CFG_W-1:0]  w_eff;
	logic [CFG_W-1:0]  h_eff;
	logic [FACT_W-1:0] f_eff;
	logic              row_end;
	logic              frame_last;

	// Per-word working registers.
	logic signed [SUM_W-1:0] y_sum_q;
	logic signed [SUM_W-1:0] cb_sum_q;
	logic signed [SUM_W-1:0] cr_sum_q;
	logic [CNT_W-1:0]        cc_hold_q;
	logic [RibW-1:0]         rib_hold_q;
	logic                    frame_last_q;
	logic [DivpW-1:0]        divp_q;
	logic [AddrW-1:0]        idx_q;
	logic                    acc_en_q;
	logic                    blk_last_q;
	logic [PIX_W-1:0]        luma_q;
	logic [PIX_W-1:0]        cb_q;
	logic [PIX_W-1:0]        cr_q;
	logic [SumQW-1:0]        scb_q;
	logic [SumQW-1:0]        scr_q;
	logic                    valid_q;
	logic [AvgpW-1:0]        qcb_q;
	logic [AvgpW-1:0]        qcr_q;
	logic [PIX_W-1:0]        luma_out_q;
	logic [PIX_W-1:0]        cb_out_q;
	logic [PIX_W-1:0]        cr_out_q;
	logic                    chroma_out_q;
	logic                    last_out_q;

	logic [PIX_W-1:0]  red;
	logic [PIX_W-1:0]  green;
	logic [PIX_W-1:0]  blue;
	logic [CNT_W-1:0]  blk;
	logic [BaseW-1:0]  base;
	logic [CNT_W-1:0]  rem_full;
	logic [FACT_W-1:0] rem;
	logic              acc_en;
	logic              blk_last;
	logic [SumQW-1:0]  scb;
	logic [SumQW-1:0]  scr;

	logic                ram_we;
	logic [AddrW-1:0]    ram_waddr;
	logic [2*ACC_W-1:0]  ram_wdata;
	logic [2*ACC_W-1:0]  ram_rdata;

	assign red   = pix_data[0*PIX_W +: PIX_W];
	assign green = pix_data[1*PIX_W +: PIX_W];
	assign blue  = pix_data[2*PIX_W +: PIX_W];

	// Effective geometry after the range limits.
	always_comb begin
		if (image_width_q == '0) begin
			w_eff = CFG_W'(1);
		end else if (int'(image_width_q) > MAX_WIDTH) begin
			w_eff = CFG_W'(MAX_WIDTH);
		end else begin
			w_eff = image_width_q;
		end
		if (image_height_q == '0) begin
			h_eff = CFG_W'(1);
		end else if (int'(image_height_q) > HEIGHT_LIMIT) begin
			h_eff = CFG_W'(HEIGHT_LIMIT);
		end else begin
			h_eff = image_height_q;
		end
		if (subsample_factor_q == '0) begin
			f_eff = FACT_W'(1);
		end else if (int'(subsample_factor_q) > MAX_FACTOR) begin
			f_eff = FACT_W'(MAX_FACTOR);
		end else begin
			f_eff = subsample_factor_q;
		end
	end

	assign row_end    = (int'(column_q) + 1) >= int'(w_eff);
	assign frame_last = row_end && ((int'(row_q) + 1) >= int'(h_eff));

	// Block column and the position inside it, from the reciprocal product.
	assign blk      = divp_q[DIV_SHIFT +: CNT_W];
	assign base     = BaseW'(blk) * BaseW'(f_eff);
	assign rem_full = cc_hold_q - base[CNT_W-1:0];
	assign rem      = rem_full[FACT_W-1:0];
	assign acc_en   = (int'(base) + int'(f_eff)) <= int'(w_eff);
	assign blk_last = ((int'(rib_hold_q) + 1) >= int'(f_eff)) && (rem == f_eff - FACT_W'(1));

	// The first row of a block overwrites whatever the accumulator held.
	always_comb begin
		if (rib_hold_q == '0) begin
			scb = SumQW'(cb_q);
			scr = SumQW'(cr_q);
		end else begin
			scb = SumQW'(ram_rdata[0 +: ACC_W]) + SumQW'(cb_q);
			scr = SumQW'(ram_rdata[ACC_W +: ACC_W]) + SumQW'(cr_q);
		end
	end

	assign ram_we    = cmd.clear || (cmd.accum && acc_en_q);
	assign ram_waddr = cmd.clear ? clear_addr_q : idx_q;
	assign ram_wdata = cmd.clear ? '0 : {scr[ACC_W-1:0], scb[ACC_W-1:0]};

	rgbycc_ram #(
		.WIDTH(2 * ACC_W),
		.DEPTH(MAX_WIDTH)
	) u_accum_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.read),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	assign status.clear_done = cmd.clear && (clear_addr_q == AddrW'(MAX_WIDTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q      <= RST_WIDTH;
			image_height_q     <= RST_HEIGHT;
			subsample_factor_q <= RST_FACTOR;
			column_q           <= '0;
			row_q              <= '0;
			rib_q              <= '0;
			clear_addr_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WIDTH:  image_width_q      <= cfg_data;
					REG_HEIGHT: image_height_q     <= cfg_data;
					REG_FACTOR: subsample_factor_q <= cfg_data[FACT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.clear) begin
				clear_addr_q <= clear_addr_q + AddrW'(1);
			end
			if (cmd.capture) begin
				if (row_end) begin
					column_q <= '0;
					if (frame_last) begin
						row_q <= '0;
						rib_q <= '0;
					end else begin
						row_q <= row_q + CNT_W'(1);
						if ((int'(rib_q) + 1) >= int'(f_eff)) begin
							rib_q <= '0;
						end else begin
							rib_q <= rib_q + RibW'(1);
						end
					end
				end else begin
					column_q <= column_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			y_sum_q  <= SUM_W'(Y_OFF + Y_R * int'(red) + Y_G * int'(green) + Y_B * int'(blue));
			cb_sum_q <= SUM_W'(CB_OFF + CB_R * int'(red) + CB_G * int'(green)
				+ CB_B * int'(blue));
			cr_sum_q <= SUM_W'(CR_OFF + CR_R * int'(red) + CR_G * int'(green)
				+ CR_B * int'(blue));
			cc_hold_q    <= column_q;
			rib_hold_q   <= rib_q;
			frame_last_q <= frame_last;
			divp_q       <= DivpW'(column_q) * DivpW'(COL_RECIP[f_eff]);
		end
		if (cmd.split) begin
			idx_q      <= AddrW'(blk);
			acc_en_q   <= acc_en;
			blk_last_q <= blk_last;
			luma_q     <= clamp_q16(y_sum_q);
			cb_q       <= clamp_q16(cb_sum_q);
			cr_q       <= clamp_q16(cr_sum_q);
		end
		if (cmd.accum) begin
			scb_q   <= scb;
			scr_q   <= scr;
			valid_q <= acc_en_q && blk_last_q;
		end
		if (cmd.average) begin
			qcb_q <= AvgpW'(scb_q) * AvgpW'(AVG_RECIP[f_eff]);
			qcr_q <= AvgpW'(scr_q) * AvgpW'(AVG_RECIP[f_eff]);
		end
		if (cmd.load) begin
			luma_out_q   <= luma_q;
			chroma_out_q <= valid_q;
			cb_out_q     <= valid_q ? qcb_q[AVG_SHIFT +: PIX_W] : '0;
			cr_out_q     <= valid_q ? qcr_q[AVG_SHIFT +: PIX_W] : '0;
			last_out_q   <= frame_last_q;
		end
	end

	assign out_data   = {cr_out_q, cb_out_q, luma_out_q};
	assign out_chroma = chroma_out_q;
	assign out_last   = last_out_q;

	a_rib_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(rib_q) < MAX_FACTOR)
		else $error("row-in-block counter beyond the largest block side");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accum && acc_en_q) |-> (int'(idx_q) < MAX_WIDTH))
		else $error("accumulator write outside the store");

	a_avg_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.average |-> $past(cmd.accum))
		else $error("average taken without a fresh block sum");

endmodule

>>> sim/rgbycc_checker.sv
// Scoreboard for the colour converter: predicts each result word and checks it on the way out.
module rgbycc_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	input  logic                             s_axis_tready,
	input  logic [rgbycc_pkg::IN_W-1:0]      s_axis_tdata,  // red, green, blue
	input  logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	input  logic [rgbycc_pkg::OUT_W-1:0]     m_axis_tdata,  // luma, blue_diff, red_diff
	input  logic                             m_axis_tuser,  // chroma_valid
	input  logic                             m_axis_tlast,  // frame_end
	input  logic                             cfg_we,
	input  logic [rgbycc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rgbycc_pkg::CFG_W-1:0]     cfg_data,
	output int                               words_due,
	output int                               word_errors
);
	import rgbycc_pkg::*;

	localparam int unsigned STORE_DEPTH = 4096;
	localparam int unsigned FACTOR_CAP  = 4;
	localparam int unsigned ROWS_CAP    = 4096;
	localparam int unsigned REPORT_MAX  = 10;

	// BT.601 studio range, Q16.
	localparam longint LUMA_BIAS   = 64'sd16 <<< 16;
	localparam longint CHROMA_BIAS = 64'sd128 <<< 16;
	localparam longint KY_R  = 16829;
	localparam longint KY_G  = 33039;
	localparam longint KY_B  = 6416;
	localparam longint KCB_R = 9714;
	localparam longint KCB_G = 19070;
	localparam longint KCB_B = 28784;
	localparam longint KCR_R = 28784;
	localparam longint KCR_G = 24103;
	localparam longint KCR_B = 4681;

	typedef struct packed {
		logic [7:0] luma;
		logic       chroma_valid;
		logic [7:0] blue_diff;
		logic [7:0] red_diff;
		logic       frame_end;
	} ycc_word_t;

	logic [CFG_W-1:0]  width_reg;
	logic [CFG_W-1:0]  height_reg;
	logic [FACT_W-1:0] factor_reg;
	logic [15:0]       cb_sum [STORE_DEPTH];
	logic [15:0]       cr_sum [STORE_DEPTH];
	int unsigned       col_pos;
	int unsigned       row_pos;
	int unsigned       row_in_blk;
	ycc_word_t         ycc_words_due [$];
	int                err_total = 0;

	function automatic logic [7:0] q16_to_pixel(input longint acc);
		if (acc < 0)
			return 8'h00;
		if ((acc >>> 16) > 255)
			return 8'hFF;
		return acc[23:16];
	endfunction

	task automatic predict_word(input logic [7:0] r, g, b, output ycc_word_t w);
		int unsigned eff_w, eff_h, eff_f, blk, idx, cb, cr, cb_total, cr_total;
		longint rs, gs, bs;
		logic row_end, frame_last;
		eff_w = (width_reg == 0) ? 1 : ((width_reg > STORE_DEPTH) ? STORE_DEPTH : width_reg);
		eff_h = (height_reg == 0) ? 1 : ((height_reg > ROWS_CAP) ? ROWS_CAP : height_reg);
		eff_f = (factor_reg == 0) ? 1 : ((factor_reg > FACTOR_CAP) ? FACTOR_CAP : factor_reg);
		rs = r;
		gs = g;
		bs = b;
		w = '0;
		w.luma = q16_to_pixel(LUMA_BIAS + KY_R * rs + KY_G * gs + KY_B * bs);
		cb = q16_to_pixel(CHROMA_BIAS - KCB_R * rs - KCB_G * gs + KCB_B * bs);
		cr = q16_to_pixel(CHROMA_BIAS + KCR_R * rs - KCR_G * gs - KCR_B * bs);

		row_end    = (col_pos + 1 >= eff_w);
		frame_last = row_end && (row_pos + 1 >= eff_h);

		// Columns right of the last whole block column are never accumulated.
		blk = col_pos / eff_f;
		if ((blk + 1) * eff_f <= eff_w) begin
			idx = blk % STORE_DEPTH;
			if (row_in_blk == 0) begin
				cb_total = cb;
				cr_total = cr;
			end else begin
				cb_total = cb_sum[idx] + cb;
				cr_total = cr_sum[idx] + cr;
			end
			cb_sum[idx] = cb_total[15:0];
			cr_sum[idx] = cr_total[15:0];
			if (row_in_blk + 1 >= eff_f && col_pos % eff_f == eff_f - 1) begin
				w.chroma_valid = 1'b1;
				w.blue_diff    = 8'(cb_total / (eff_f * eff_f));
				w.red_diff     = 8'(cr_total / (eff_f * eff_f));
			end
		end
		w.frame_end = frame_last;

		if (row_end) begin
			col_pos = 0;
			if (frame_last) begin
				row_pos    = 0;
				row_in_blk = 0;
			end else begin
				row_pos    = (row_pos + 1) & 32'hFFF;
				row_in_blk = (row_in_blk + 1 >= eff_f) ? 0 : row_in_blk + 1;
			end
		end else begin
			col_pos = (col_pos + 1) & 32'hFFF;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		ycc_word_t got, due;
		if (!arst_n) begin
			width_reg  = RST_WIDTH;
			height_reg = RST_HEIGHT;
			factor_reg = RST_FACTOR;
			for (int i = 0; i < STORE_DEPTH; i++) begin
				cb_sum[i] = '0;
				cr_sum[i] = '0;
			end
			col_pos    = 0;
			row_pos    = 0;
			row_in_blk = 0;
			ycc_words_due.delete();
			words_due <= 0;
		end else begin
			// Check outgoing words before queueing the incoming one of the same edge.
			if (m_axis_tvalid && m_axis_tready) begin
				got.luma         = m_axis_tdata[7:0];
				got.chroma_valid = m_axis_tuser;
				got.blue_diff    = m_axis_tdata[15:8];
				got.red_diff     = m_axis_tdata[23:16];
				got.frame_end    = m_axis_tlast;
				if (ycc_words_due.size() == 0) begin
					err_total++;
					if (err_total <= REPORT_MAX)
						$display("%0t: result word with none due: ", $time,
							"luma %0d cv %0b cb %0d cr %0d last %0b",
							got.luma, got.chroma_valid, got.blue_diff, got.red_diff,
							got.frame_end);
				end else begin
					due = ycc_words_due.pop_front();
					if (got.luma !== due.luma || got.chroma_valid !== due.chroma_valid ||
							got.blue_diff !== due.blue_diff || got.red_diff !== due.red_diff ||
							got.frame_end !== due.frame_end) begin
						err_total++;
						if (err_total <= REPORT_MAX)
							$display("%0t: result mismatch: ", $time,
								"due luma %0d cv %0b cb %0d cr %0d last %0b, ",
								due.luma, due.chroma_valid, due.blue_diff, due.red_diff,
								due.frame_end,
								"got luma %0d cv %0b cb %0d cr %0d last %0b",
								got.luma, got.chroma_valid, got.blue_diff,
								got.red_diff, got.frame_end);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_WIDTH:  width_reg  = cfg_data;
					REG_HEIGHT: height_reg = cfg_data;
					REG_FACTOR: factor_reg = cfg_data[FACT_W-1:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				predict_word(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16], due);
				ycc_words_due = {ycc_words_due, due};
			end
			words_due <= ycc_words_due.size();
		end
		word_errors <= err_total;
	end

endmodule

>>> sim/tb_rgb_to_ycbcr_chroma_subsample_core.sv
// Testbench top: drives pixel words and register writes into the converter and gives the verdict.
module tb_rgb_to_ycbcr_chroma_subsample_core;
	import rgbycc_pkg::*;

	localparam int RUN_LIMIT = 10_000_000;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [IN_W-1:0]      s_axis_tdata = '0;   // red, green, blue
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [OUT_W-1:0]     m_axis_tdata;        // luma, blue_diff, red_diff
	logic                 m_axis_tuser;        // chroma_valid
	logic                 m_axis_tlast;        // frame_end
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int words_due;
	int word_errors;

	rgb_to_ycbcr_chroma_subsample_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	rgbycc_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.words_due     (words_due),
		.word_errors   (word_errors)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	initial begin
		#(RUN_LIMIT);
		$display("** rgb_to_ycbcr_chroma_subsample_core: FAILED **");
		$finish;
	end

	function automatic logic [7:0] random_channel();
		int unsigned pick;
		pick = $urandom_range(0, 7);
		if (pick == 0)
			return 8'h00;
		if (pick == 1)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				src_idle_pct   = 0;
				sink_stall_pct = 0;
			end
			IDLE_SENDER: begin
				src_idle_pct   = 48;
				sink_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				src_idle_pct   = 0;
				sink_stall_pct = 48;
			end
			default: begin
				src_idle_pct   = 31;
				sink_stall_pct = 31;
			end
		endcase
	endtask

	// tvalid stays high from one word to the next unless a gap is drawn.
	task automatic send_pixel(input logic [7:0] r, g, b);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {b, g, r};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (words_due != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	// Frame geometry changes only once the block has nothing in flight.
	task automatic program_frame(input int unsigned w, h, f);
		drain();
		write_reg(REG_WIDTH, w[CFG_W-1:0]);
		write_reg(REG_HEIGHT, h[CFG_W-1:0]);
		write_reg(REG_FACTOR, f[CFG_W-1:0]);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_random(input int n, input bit pause_midway);
		for (int i = 0; i < n; i++) begin
			if (pause_midway && i == n / 2)
				drain();
			send_pixel(random_channel(), random_channel(), random_channel());
		end
	endtask

	initial begin
		int unsigned w, h, f;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Colour corners and two mid-range colours under the reset geometry.
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'hFF, 8'h00, 8'h00);
		send_pixel(8'h00, 8'hFF, 8'h00);
		send_pixel(8'h00, 8'h00, 8'hFF);
		send_pixel(8'h00, 8'hFF, 8'hFF);
		send_pixel(8'hFF, 8'h00, 8'hFF);
		send_pixel(8'hFF, 8'hFF, 8'h00);
		send_pixel(8'h80, 8'h80, 8'h80);
		send_pixel(8'h55, 8'hAA, 8'h01);
		drain();

		// Zero sizes act as one: every word is a whole frame and a whole block.
		program_frame(0, 0, 0);
		send_pixel(8'hFF, 8'h00, 8'h7F);
		send_pixel(8'h00, 8'hFF, 8'h80);
		send_pixel(8'h12, 8'h34, 8'h56);

		// Oversized registers saturate; the counters carry on from the last frame.
		program_frame(8191, 8191, 7);
		send_pixel(8'hFE, 8'h01, 8'hFE);
		send_pixel(8'h01, 8'hFE, 8'h01);
		send_pixel(8'hFF, 8'hFF, 8'h00);
		send_pixel(8'h00, 8'h00, 8'hFF);

		// Narrow frame with a ragged right edge and bottom, entered mid-row.
		program_frame(7, 5, 3);
		for (int i = 0; i < 8; i++)
			send_pixel(8'(i * 37), 8'(255 - i * 29), 8'(i * 91));

		for (int p = 0; p < 16; p++) begin
			case ($urandom_range(0, 9))
				0: w = 0;
				1: w = $urandom_range(13, 48);
				default: w = $urandom_range(1, 12);
			endcase
			case ($urandom_range(0, 9))
				0: h = 0;
				1: h = $urandom_range(9, 20);
				default: h = $urandom_range(1, 8);
			endcase
			f = $urandom_range(0, 7);
			program_frame(w, h, f);
			set_idling(idle_mode_t'(p % 4));
			send_random($urandom_range(80, 140), $urandom_range(0, 2) == 0);
		end

		// A short run at the widest setting.
		program_frame(4096, 1, 1);
		set_idling(IDLE_NONE);
		send_random(40, 1'b0);

		program_frame(3, 4096, 4);
		set_idling(IDLE_BOTH);
		send_random(60, 1'b1);

		drain();
		repeat (12) @(posedge clk);
		if (word_errors == 0 && words_due == 0)
			$display("** rgb_to_ycbcr_chroma_subsample_core: PASSED **");
		else
			$display("** rgb_to_ycbcr_chroma_subsample_core: FAILED **");
		$finish;
	end

endmodule

>>> files.f
src/rgbycc_pkg.sv
src/rgbycc_ram.sv
src/rgbycc_ctrl.sv
src/rgbycc_dp.sv
src/rgb_to_ycbcr_chroma_subsample_core.sv
sim/rgbycc_checker.sv
sim/tb_rgb_to_ycbcr_chroma_subsample_core.sv
